// ===== src/lbde_pkg.sv =====
// Shared types, constants and saturation helpers for the Legendre basis evaluator.
package lbde_pkg;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RECIP,
    ST_RNEG,
    ST_INIT1,
    ST_STEP_CHK,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_DIV,
    ST_AUX,
    ST_ORD_CHK,
    ST_SC_LOAD,
    ST_SC_MUL,
    ST_SC_CMD,
    ST_EMIT,
    ST_ZERO
  } state_t;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_SAT  = 2'd1;
  localparam logic [1:0] STATUS_TAU0 = 2'd2;

  localparam logic signed [63:0] ONE_Q24   = 64'sh0000_0000_0100_0000;
  localparam logic signed [63:0] VAL_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] VAL_MIN   = 64'sh8000_0000_0000_0000;
  localparam logic [63:0]        RECIP_NUM = 64'h0002_0000_0000_0000;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [5:0]         sh;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic signed [63:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] n;
    logic [31:0] dv;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } div_rsp_t;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    mag = a[63] ? (~a + 64'd1) : a;
  endfunction

  // Returns {overflow, value}.
  function automatic logic [64:0] from_mag(input logic [63:0] q, input logic neg);
    logic [64:0] r;
    if (neg) begin
      if (q > 64'h8000_0000_0000_0000) r = {1'b1, VAL_MIN};
      else                             r = {1'b0, ~q + 64'd1};
    end else begin
      if (q[63]) r = {1'b1, VAL_MAX};
      else       r = {1'b0, q};
    end
    from_mag = r;
  endfunction

  function automatic logic [64:0] sat_add(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [63:0] s;
    logic [64:0] r;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) r = {1'b1, a[63] ? VAL_MIN : VAL_MAX};
    else                                  r = {1'b0, s};
    sat_add = r;
  endfunction

  function automatic logic [64:0] sat_sub(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
    logic signed [63:0] s;
    logic [64:0] r;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) r = {1'b1, a[63] ? VAL_MIN : VAL_MAX};
    else                                  r = {1'b0, s};
    sat_sub = r;
  endfunction

endpackage

// ===== src/lbde_mul.sv =====
// Multi-cycle 64 by 64 signed multiplier with rounding shift and saturation.
module lbde_mul (
  input  logic                clk,
  input  logic                rst,
  input  lbde_pkg::mul_req_t  req,
  output lbde_pkg::mul_rsp_t  rsp
);

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic [5:0]   sh;
  logic [127:0] acc;
  logic [2:0]   step;
  logic         run;
  logic         done;
  logic         ovf;
  logic signed [63:0] res;

  logic [31:0]  xa;
  logic [31:0]  xb;
  logic [63:0]  pp;
  logic [6:0]   off;
  logic [127:0] half;
  logic [127:0] rnd;
  logic [127:0] q;
  logic [64:0]  fm;

  // One 32 by 32 partial product a cycle.
  always_comb begin
    xa = step[1] ? ua[63:32] : ua[31:0];
    xb = step[0] ? ub[63:32] : ub[31:0];
    pp = xa * xb;
    case (step)
      3'd0:    off = 7'd0;
      3'd1:    off = 7'd32;
      3'd2:    off = 7'd32;
      3'd3:    off = 7'd64;
      default: off = 7'd0;
    endcase
    half = (sh == 6'd0) ? 128'd0 : (128'd1 << (sh - 6'd1));
    rnd  = acc + half;
    q    = rnd >> sh;
    fm   = lbde_pkg::from_mag(q[63:0], neg);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        step <= 3'd0;
        acc  <= 128'd0;
        ua   <= lbde_pkg::mag(req.a);
        ub   <= lbde_pkg::mag(req.b);
        neg  <= req.a[63] ^ req.b[63];
        sh   <= req.sh;
      end else if (run) begin
        if (step == 3'd4) begin
          run  <= 1'b0;
          done <= 1'b1;
          if (|q[127:64]) begin
            ovf <= 1'b1;
            res <= neg ? lbde_pkg::VAL_MIN : lbde_pkg::VAL_MAX;
          end else begin
            ovf <= fm[64];
            res <= fm[63:0];
          end
        end else begin
          acc  <= acc + ({64'd0, pp} << off);
          step <= step + 3'd1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.res  = res;

endmodule

// ===== src/lbde_div.sv =====
// Restoring divider, one quotient bit a cycle, 64-bit dividend by 32-bit divisor.
module lbde_div (
  input  logic                clk,
  input  logic                rst,
  input  lbde_pkg::div_req_t  req,
  output lbde_pkg::div_rsp_t  rsp
);

  logic [32:0] rem;
  logic [63:0] quo;
  logic [31:0] dv;
  logic [6:0]  cnt;
  logic        run;
  logic        done;
  logic [32:0] shifted;
  logic [33:0] trial;

  always_comb begin
    shifted = {rem[31:0], quo[63]};
    trial   = {1'b0, shifted} - {2'b00, dv};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        rem <= 33'd0;
        quo <= req.n;
        dv  <= req.dv;
        cnt <= 7'd64;
      end else if (run) begin
        if (trial[33]) begin
          rem <= shifted;
          quo <= {quo[62:0], 1'b0};
        end else begin
          rem <= trial[32:0];
          quo <= {quo[62:0], 1'b1};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.q    = quo;

endmodule

// ===== src/legendre_basis_derivative_eval.sv =====
// Legendre basis evaluator with derivatives: sequencer around a shared multiplier and divider.
// Sequence: the reciprocal of tau is taken by one rounding division, and each recurrence step
// uses up to four multiplies and one rounding division; zero cases emit a zero value for
// each of the dim basis entries.
// Throughput: one item at a time; busy stays high until the last beat has been issued.
// Reset (synchronous, active high) returns the sequencer to idle and dim_in_use to 4.
module legendre_basis_derivative_eval #(
  parameter int MAX_DIM = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic signed [31:0] point_s,
  input  logic [31:0]        window_tau,
  input  logic [3:0]         deriv_order,
  output logic               result_valid,
  output logic [3:0]         basis_index,
  output logic signed [63:0] basis_value,
  output logic               last_value,
  output logic [1:0]         status
);

  localparam int IW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
  localparam int DW = $clog2(MAX_DIM + 1);

  lbde_pkg::state_t state, state_next;

  // Configuration register.
  logic [4:0] dim_in_use;

  // Item context.
  logic [DW-1:0]      dim;
  logic               cmd;
  logic signed [63:0] s;
  logic [31:0]        window_tau_q;
  logic               tau_zero;
  logic [3:0]         deg;

  // Sequencer counters.
  logic [IW-1:0] i;
  logic [3:0]    d;
  logic [3:0]    k;

  // Working values.
  logic signed [63:0] t;
  logic               acc_ovf;
  logic signed [63:0] a0;
  logic signed [63:0] a1;
  logic               a0s;
  logic               a1s;
  logic signed [63:0] aux;
  logic               asat;
  logic signed [63:0] r;
  logic signed [63:0] rneg;
  logic signed [63:0] v;
  logic               vsat;

  // Polynomial values of the current order, updated in place.
  logic signed [63:0] cur [MAX_DIM];
  logic               cs  [MAX_DIM];

  logic pend_mul;
  logic pend_div;

  lbde_pkg::mul_req_t mul_req;
  lbde_pkg::mul_rsp_t mul_rsp;
  lbde_pkg::div_req_t div_req;
  lbde_pkg::div_rsp_t div_rsp;

  logic [5:0]    cfg6;
  logic [DW-1:0] dim_c;
  logic          zero_c;
  logic [DW:0]   ip1;
  logic          step_more;
  logic          is_last;
  logic          k_last;
  logic [31:0]   ip1_32;
  logic signed [63:0] cur_rd;
  logic               cs_rd;
  logic [64:0]   add_r;
  logic [64:0]   sub_r;
  logic [64:0]   dq;
  logic          ns;
  logic          mul_state;
  logic          div_state;
  logic [5:0]    i6;

  // APB: a single register, always ready.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {27'd0, dim_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      dim_in_use <= 5'd4;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      dim_in_use <= pwdata[4:0];
    end
  end

  // The register value is clamped to the supported range when an item is taken.
  always_comb begin
    cfg6 = {1'b0, dim_in_use};
    if (cfg6 < 6'd2)                 dim_c = DW'(2);
    else if (cfg6 > 6'(MAX_DIM))     dim_c = DW'(MAX_DIM);
    else                             dim_c = DW'(cfg6);
    zero_c = (window_tau == 32'd0) || ({2'b00, deriv_order} >= 6'(dim_c));
  end

  always_comb begin
    ip1       = (DW+1)'(i) + (DW+1)'(1);
    step_more = ip1 < (DW+1)'(dim);
    is_last   = ip1 == (DW+1)'(dim);
    k_last    = (k + 4'd1) == deg;
    ip1_32    = 32'(i) + 32'd1;
    cur_rd    = cur[i];
    cs_rd     = cs[i];
    add_r     = lbde_pkg::sat_add(t, mul_rsp.res);
    sub_r     = lbde_pkg::sat_sub(t, mul_rsp.res);
    dq        = lbde_pkg::from_mag(div_rsp.q, t[63]);
    ns        = acc_ovf | dq[64] | a1s | a0s | ((d != 4'd0) & cs_rd);
    i6        = 6'(i);
  end

  assign busy = (state != lbde_pkg::ST_IDLE);

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      lbde_pkg::ST_IDLE:
        if (start) state_next = zero_c ? lbde_pkg::ST_ZERO : lbde_pkg::ST_RECIP;
      lbde_pkg::ST_RECIP:
        if (div_rsp.done) state_next = lbde_pkg::ST_RNEG;
      lbde_pkg::ST_RNEG:
        if (mul_rsp.done) state_next = lbde_pkg::ST_INIT1;
      lbde_pkg::ST_INIT1:
        if (mul_rsp.done) state_next = lbde_pkg::ST_STEP_CHK;
      lbde_pkg::ST_STEP_CHK: begin
        if (step_more)       state_next = (d != 4'd0) ? lbde_pkg::ST_M1 : lbde_pkg::ST_M2;
        else if (d == 4'd0)  state_next = lbde_pkg::ST_ORD_CHK;
        else                 state_next = lbde_pkg::ST_AUX;
      end
      lbde_pkg::ST_M1:
        if (mul_rsp.done) state_next = lbde_pkg::ST_M2;
      lbde_pkg::ST_M2:
        if (mul_rsp.done) state_next = lbde_pkg::ST_M3;
      lbde_pkg::ST_M3:
        if (mul_rsp.done) state_next = lbde_pkg::ST_M4;
      lbde_pkg::ST_M4:
        if (mul_rsp.done) state_next = lbde_pkg::ST_DIV;
      lbde_pkg::ST_DIV:
        if (div_rsp.done) state_next = lbde_pkg::ST_STEP_CHK;
      lbde_pkg::ST_AUX:
        if (mul_rsp.done) state_next = lbde_pkg::ST_ORD_CHK;
      lbde_pkg::ST_ORD_CHK:
        state_next = (d < deg) ? lbde_pkg::ST_STEP_CHK : lbde_pkg::ST_SC_LOAD;
      lbde_pkg::ST_SC_LOAD: begin
        if (deg != 4'd0) state_next = lbde_pkg::ST_SC_MUL;
        else if (cmd)    state_next = lbde_pkg::ST_SC_CMD;
        else             state_next = lbde_pkg::ST_EMIT;
      end
      lbde_pkg::ST_SC_MUL:
        if (mul_rsp.done && k_last) state_next = cmd ? lbde_pkg::ST_SC_CMD : lbde_pkg::ST_EMIT;
      lbde_pkg::ST_SC_CMD:
        if (mul_rsp.done) state_next = lbde_pkg::ST_EMIT;
      lbde_pkg::ST_EMIT:
        state_next = is_last ? lbde_pkg::ST_IDLE : lbde_pkg::ST_SC_LOAD;
      lbde_pkg::ST_ZERO:
        state_next = is_last ? lbde_pkg::ST_IDLE : lbde_pkg::ST_ZERO;
      default:
        state_next = lbde_pkg::ST_IDLE;
    endcase
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_state = 1'b0;
    div_state = 1'b0;
    mul_req.a  = 64'sd0;
    mul_req.b  = 64'sd0;
    mul_req.sh = 6'd0;
    div_req.n  = 64'd0;
    div_req.dv = 32'd1;
    case (state)
      lbde_pkg::ST_RECIP: begin
        div_state  = 1'b1;
        div_req.n  = lbde_pkg::RECIP_NUM + 64'(window_tau_q >> 1);
        div_req.dv = window_tau_q;
      end
      lbde_pkg::ST_RNEG: begin
        mul_state = 1'b1;
        mul_req.a = r;
        mul_req.b = 64'(deg);
      end
      lbde_pkg::ST_INIT1: begin
        mul_state  = 1'b1;
        mul_req.a  = lbde_pkg::ONE_Q24;
        mul_req.b  = s;
        mul_req.sh = 6'd30;
      end
      lbde_pkg::ST_M1: begin
        mul_state = 1'b1;
        mul_req.a = cur_rd;
        mul_req.b = 64'(d);
      end
      lbde_pkg::ST_M2: begin
        mul_state  = 1'b1;
        mul_req.a  = a1;
        mul_req.b  = s;
        mul_req.sh = 6'd30;
      end
      lbde_pkg::ST_M3: begin
        mul_state = 1'b1;
        mul_req.a = t;
        mul_req.b = 64'({i, 1'b1});
      end
      lbde_pkg::ST_M4: begin
        mul_state = 1'b1;
        mul_req.a = a0;
        mul_req.b = 64'(i);
      end
      lbde_pkg::ST_DIV: begin
        div_state  = 1'b1;
        div_req.n  = lbde_pkg::mag(t) + 64'(ip1_32 >> 1);
        div_req.dv = ip1_32;
      end
      lbde_pkg::ST_AUX: begin
        mul_state = 1'b1;
        mul_req.a = aux;
        mul_req.b = 64'({d, 1'b1});
      end
      lbde_pkg::ST_SC_MUL: begin
        mul_state  = 1'b1;
        mul_req.a  = v;
        mul_req.b  = r;
        mul_req.sh = 6'd32;
      end
      lbde_pkg::ST_SC_CMD: begin
        mul_state  = 1'b1;
        mul_req.a  = v;
        mul_req.b  = rneg;
        mul_req.sh = 6'd33;
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
    mul_req.start = mul_state & ~pend_mul;
    div_req.start = div_state & ~pend_div;
  end

  lbde_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mul_req),
    .rsp (mul_rsp)
  );

  lbde_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lbde_pkg::ST_IDLE;
      pend_mul     <= 1'b0;
      pend_div     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      pend_mul     <= mul_req.start ? 1'b1 : (mul_rsp.done ? 1'b0 : pend_mul);
      pend_div     <= div_req.start ? 1'b1 : (div_rsp.done ? 1'b0 : pend_div);
      result_valid <= (state == lbde_pkg::ST_EMIT) || (state == lbde_pkg::ST_ZERO);
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state)
      lbde_pkg::ST_IDLE: begin
        if (start) begin
          dim          <= dim_c;
          cmd          <= command;
          s            <= 64'(point_s);
          window_tau_q <= window_tau;
          tau_zero     <= (window_tau == 32'd0);
          deg          <= deriv_order;
          i            <= '0;
          d            <= 4'd0;
          aux          <= lbde_pkg::ONE_Q24;
          asat         <= 1'b0;
        end
      end
      lbde_pkg::ST_RECIP: begin
        if (div_rsp.done) r <= div_rsp.q;
      end
      lbde_pkg::ST_RNEG: begin
        if (mul_rsp.done) rneg <= -mul_rsp.res;
      end
      lbde_pkg::ST_INIT1: begin
        if (mul_rsp.done) begin
          cur[0] <= lbde_pkg::ONE_Q24;
          cs[0]  <= 1'b0;
          cur[1] <= mul_rsp.res;
          cs[1]  <= mul_rsp.ovf;
          a0     <= lbde_pkg::ONE_Q24;
          a0s    <= 1'b0;
          a1     <= mul_rsp.res;
          a1s    <= mul_rsp.ovf;
          i      <= IW'(1);
        end
      end
      lbde_pkg::ST_STEP_CHK: begin
        t       <= 64'sd0;
        acc_ovf <= 1'b0;
        // End of a derivative order: the top entry takes its new value.
        if (!step_more && d != 4'd0) begin
          cur[i] <= a1;
          cs[i]  <= a1s;
        end
      end
      lbde_pkg::ST_M1, lbde_pkg::ST_M3: begin
        if (mul_rsp.done) begin
          t       <= mul_rsp.res;
          acc_ovf <= acc_ovf | mul_rsp.ovf;
        end
      end
      lbde_pkg::ST_M2: begin
        if (mul_rsp.done) begin
          t       <= add_r[63:0];
          acc_ovf <= acc_ovf | mul_rsp.ovf | add_r[64];
        end
      end
      lbde_pkg::ST_M4: begin
        if (mul_rsp.done) begin
          t       <= sub_r[63:0];
          acc_ovf <= acc_ovf | mul_rsp.ovf | sub_r[64];
        end
      end
      lbde_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          // Plain evaluation writes ahead; a derivative order retires the entry just read.
          if (d == 4'd0) begin
            cur[IW'(ip1)] <= dq[63:0];
            cs[IW'(ip1)]  <= ns;
          end else begin
            cur[i] <= a1;
            cs[i]  <= a1s;
          end
          a0  <= a1;
          a0s <= a1s;
          a1  <= dq[63:0];
          a1s <= ns;
          i   <= IW'(ip1);
        end
      end
      lbde_pkg::ST_AUX: begin
        if (mul_rsp.done) begin
          aux  <= mul_rsp.res;
          asat <= asat | mul_rsp.ovf;
        end
      end
      lbde_pkg::ST_ORD_CHK: begin
        if (d < deg) begin
          cur[IW'(d)] <= 64'sd0;
          cs[IW'(d)]  <= 1'b0;
          d           <= d + 4'd1;
          i           <= IW'(d + 4'd1);
          a0          <= 64'sd0;
          a0s         <= 1'b0;
          a1          <= aux;
          a1s         <= asat;
        end else begin
          i <= '0;
        end
      end
      lbde_pkg::ST_SC_LOAD: begin
        v    <= cur_rd;
        vsat <= cs_rd;
        k    <= 4'd0;
      end
      lbde_pkg::ST_SC_MUL: begin
        if (mul_rsp.done) begin
          v    <= mul_rsp.res;
          vsat <= vsat | mul_rsp.ovf;
          k    <= k + 4'd1;
        end
      end
      lbde_pkg::ST_SC_CMD: begin
        if (mul_rsp.done) begin
          v    <= mul_rsp.res;
          vsat <= vsat | mul_rsp.ovf;
        end
      end
      lbde_pkg::ST_EMIT: begin
        basis_index <= i6[3:0];
        basis_value <= v;
        last_value  <= is_last;
        status      <= vsat ? lbde_pkg::STATUS_SAT : lbde_pkg::STATUS_OK;
        i           <= IW'(ip1);
      end
      lbde_pkg::ST_ZERO: begin
        basis_index <= i6[3:0];
        basis_value <= 64'sd0;
        last_value  <= is_last;
        status      <= tau_zero ? lbde_pkg::STATUS_TAU0 : lbde_pkg::STATUS_OK;
        i           <= IW'(ip1);
      end
      default: begin
        t <= t;
      end
    endcase
  end

endmodule
